[rtl/ycl_pkg.sv]
// shared types and constants for the bt.709 ycbcr to linear rgb converter
// no dependencies; imported by ycl_lane, ycbcr709_to_linear_rgb and the testbench
package ycl_pkg;

    // sample depth register codes
    typedef enum logic [1:0] {
        DEPTH_8   = 2'd0,
        DEPTH_10  = 2'd1,
        DEPTH_12  = 2'd2,
        DEPTH_BAD = 2'd3
    } depth_mode_t;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IQ            = 24;   // internal fraction bits
    localparam int SMP_W         = 12;   // sample width
    localparam int OUT_W         = 20;   // colour result width
    localparam int CH_W          = 40;   // matrix output, q24 code units
    localparam int LANE_LAT      = 11;   // register stages in one colour lane

    // matrix coefficients, q20
    localparam int C_YEXP = 1220945;
    localparam int C_RV   = 1879782;
    localparam int C_GU   = 223556;
    localparam int C_GV   = 558786;
    localparam int C_BU   = 2215012;

    // 1/4.5 in q32, linear segment knee in q24
    localparam int RECIP45    = 954437177;
    localparam int LIN_THRESH = 1358954;

    // curve coefficients, q24
    localparam int P_A = -696926;
    localparam int P_B = 3558112;
    localparam int P_C = 12187641;
    localparam int P_D = 1642171;
    localparam int P_E = 86151;

    // output saturation bounds
    localparam int OUT_MIN = -131072;
    localparam int OUT_MAX = 524287;

endpackage

[rtl/ycl_lane.sv]
// one colour lane: code value to linear light, rounded and saturated
// depends on ycl_pkg; eleven register stages, advances every cycle
module ycl_lane
    import ycl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic signed [CH_W-1:0]  chan,
    output logic signed [OUT_W-1:0] lin
);

    localparam int CC_W  = 38;          // clamped channel
    localparam int T_W   = CC_W + 9;    // channel * 257
    localparam int P_W   = 64;          // channel * 0x01010101
    localparam int X_W   = 30;          // x in q24
    localparam int XC_W  = 29;          // curve input, capped at 8
    localparam int M1_W  = 50;
    localparam int LP_W  = 61;
    localparam int R_W   = 32;
    localparam int M_W   = R_W + XC_W;
    localparam int R_SH  = 32;
    localparam int SH    = IQ - FRAC_BITS;

    localparam logic signed [CH_W-1:0] C_CLAMP  = CH_W'(64'sd1 <<< 36);
    localparam logic signed [P_W-1:0]  HALF32   = 64'sd1 <<< (R_SH - 1);
    localparam logic signed [63:0]     HALF_IQ  = 64'sd1 <<< (IQ - 1);
    localparam logic signed [63:0]     HALF_OUT = (64'sd1 <<< SH) >>> 1;
    localparam logic signed [X_W-1:0]  X_THR    = X_W'(LIN_THRESH);
    localparam logic signed [X_W-1:0]  X_CAP    = X_W'(64'sd1 <<< (IQ + 3));
    localparam logic signed [R_W-1:0]  O_LO     = R_W'(OUT_MIN);
    localparam logic signed [R_W-1:0]  O_HI     = R_W'(OUT_MAX);

    logic signed [CC_W-1:0]  c_cl;
    logic signed [T_W-1:0]   t_next, t_reg;
    logic signed [P_W-1:0]   p_sum;
    logic signed [X_W-1:0]   x_next, x_reg;
    logic                    below_next;
    logic signed [XC_W-1:0]  xc_next;
    logic signed [M1_W-1:0]  m1_next, m1_reg, m1_rnd;
    logic signed [LP_W-1:0]  lp_next, lp_reg, lp_rnd;
    logic signed [R_W-1:0]   r1_next, r1_reg, lin0_next;
    logic signed [M_W-1:0]   m2_next, m2_reg, m2_rnd;
    logic signed [R_W-1:0]   r2_next, r2_reg;
    logic signed [M_W-1:0]   m3_next, m3_reg, m3_rnd;
    logic signed [R_W-1:0]   r3_next, r3_reg;
    logic signed [M_W-1:0]   m4_next, m4_reg, m4_rnd;
    logic signed [R_W-1:0]   v_next, v_reg, v_rnd, o_sh;
    logic signed [OUT_W-1:0] o_next, o_reg;

    // side lines: curve input, segment select, linear-segment value
    logic signed [XC_W-1:0]  xc_line_reg [0:5];
    logic                    below_line_reg [0:6];
    logic signed [R_W-1:0]   lin_line_reg [0:5];

    always_comb
    begin
        // large inputs land on the clamped top of the curve anyway
        c_cl   = (chan > C_CLAMP) ? CC_W'(C_CLAMP) : CC_W'(chan);
        t_next = (T_W'(c_cl) <<< 8) + T_W'(c_cl);

        // x = chan / 255 by the 0x01010101 reciprocal
        p_sum  = (P_W'(t_reg) <<< 16) + P_W'(t_reg) + HALF32;
        x_next = X_W'(p_sum >>> R_SH);

        below_next = (x_reg < X_THR);
        xc_next    = (x_reg > X_CAP) ? XC_W'(X_CAP) : XC_W'(x_reg);
        m1_next    = M1_W'(P_A) * M1_W'(xc_next);
        lp_next    = LP_W'(x_reg) * LP_W'(RECIP45);

        m1_rnd    = m1_reg + M1_W'(HALF_IQ);
        r1_next   = R_W'(m1_rnd >>> IQ) + R_W'(P_B);
        lp_rnd    = lp_reg + LP_W'(HALF32);
        lin0_next = R_W'(lp_rnd >>> R_SH);

        m2_next = M_W'(r1_reg) * M_W'(xc_line_reg[1]);
        m2_rnd  = m2_reg + M_W'(HALF_IQ);
        r2_next = R_W'(m2_rnd >>> IQ) + R_W'(P_C);

        m3_next = M_W'(r2_reg) * M_W'(xc_line_reg[3]);
        m3_rnd  = m3_reg + M_W'(HALF_IQ);
        r3_next = R_W'(m3_rnd >>> IQ) + R_W'(P_D);

        m4_next = M_W'(r3_reg) * M_W'(xc_line_reg[5]);
        m4_rnd  = m4_reg + M_W'(HALF_IQ);
        v_next  = below_line_reg[6] ? lin_line_reg[5] : R_W'(m4_rnd >>> IQ) + R_W'(P_E);

        // round to output fraction bits, then saturate
        v_rnd = v_reg + R_W'(HALF_OUT);
        o_sh  = v_rnd >>> SH;
        if (o_sh < O_LO)
        begin
            o_next = OUT_W'(O_LO);
        end
        else if (o_sh > O_HI)
        begin
            o_next = OUT_W'(O_HI);
        end
        else
        begin
            o_next = OUT_W'(o_sh);
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg  <= t_next;
        x_reg  <= x_next;
        m1_reg <= m1_next;
        lp_reg <= lp_next;
        r1_reg <= r1_next;
        m2_reg <= m2_next;
        r2_reg <= r2_next;
        m3_reg <= m3_next;
        r3_reg <= r3_next;
        m4_reg <= m4_next;
        v_reg  <= v_next;
        o_reg  <= o_next;

        xc_line_reg[0]    <= xc_next;
        below_line_reg[0] <= below_next;
        lin_line_reg[0]   <= lin0_next;
        for (int i = 1; i < 6; i++)
        begin
            xc_line_reg[i]  <= xc_line_reg[i-1];
            lin_line_reg[i] <= lin_line_reg[i-1];
        end
        for (int i = 1; i < 7; i++)
        begin
            below_line_reg[i] <= below_line_reg[i-1];
        end
    end

    assign lin = o_reg;

endmodule

[rtl/ycbcr709_to_linear_rgb.sv]
// top level: limited-range bt.709 ycbcr to linear-light rgb, one pixel per clock
// depends on ycl_pkg and ycl_lane
//
//  channel   signals                               transfer
//  --------  ------------------------------------  ----------------------------
//  pixel in  start, busy, luma, blue_diff, red_diff  edge with start=1, busy=0
//  result    done, red_lin, green_lin, blue_lin,   one cycle with done=1
//            valid_res
//  config    cfg_we, cfg_wdata (depth_mode)        edge with cfg_we=1
//
// from its transfer to its result a pixel passes through one stage for sample
// scaling, one for the matrix multipliers, one for the channel sums, eleven in
// each colour lane (reciprocal, four curve multiplies with roundings, output
// rounding) and the output register. busy never rises, so a pixel may enter
// every cycle. reset clears the valid line and the mode register (8-bit);
// there is no stall path since results cannot be held off.
module ycbcr709_to_linear_rgb
    import ycl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SMP_W-1:0]        luma,
    input  logic [SMP_W-1:0]        blue_diff,
    input  logic [SMP_W-1:0]        red_diff,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_wdata,
    output logic                    done,
    output logic signed [OUT_W-1:0] red_lin,
    output logic signed [OUT_W-1:0] green_lin,
    output logic signed [OUT_W-1:0] blue_lin,
    output logic                    valid_res
);

    localparam int D_W      = 18;            // offset-removed sample
    localparam int W16      = SMP_W + 4;     // sample scaled to 8-bit code, q4
    localparam int MUL_W    = D_W + 23;      // sample times q20 coefficient
    localparam int PIPE_LAT = 3 + LANE_LAT + 1;

    localparam logic signed [D_W-1:0] Y_OFS = D_W'(256);    // 16 in q4
    localparam logic signed [D_W-1:0] C_OFS = D_W'(2048);   // 128 in q4

    depth_mode_t depth_mode_reg;

    logic                   accept;
    logic [W16-1:0]         yw, uw, vw;

    // stage 1: scaled, offset samples
    logic signed [D_W-1:0]  dy_next, du_next, dv_next;
    logic signed [D_W-1:0]  dy_reg, du_reg, dv_reg;
    logic                   s1_valid_reg, s1_ok_reg;

    // stage 2: matrix products
    logic signed [CH_W-1:0] py_next, prv_next, pgu_next, pgv_next, pbu_next;
    logic signed [CH_W-1:0] py_reg, prv_reg, pgu_reg, pgv_reg, pbu_reg;
    logic                   s2_valid_reg, s2_ok_reg;

    // stage 3: channel sums, q24 code units
    logic signed [CH_W-1:0] r_next, g_next, b_next;
    logic signed [CH_W-1:0] r_reg, g_reg, b_reg;
    logic                   s3_valid_reg, s3_ok_reg;

    // valid and format flags alongside the colour lanes
    logic                   valid_line_reg [0:LANE_LAT-1];
    logic                   ok_line_reg    [0:LANE_LAT-1];

    logic signed [OUT_W-1:0] lane_r, lane_g, lane_b;

    logic                    done_reg, valid_res_reg;
    logic signed [OUT_W-1:0] red_reg, green_reg, blue_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= DEPTH_8;
        end
        else if (cfg_we)
        begin
            depth_mode_reg <= depth_mode_t'(cfg_wdata);
        end
    end

    // scale to 8-bit code values with four fraction bits
    always_comb
    begin
        case (depth_mode_reg)
            DEPTH_8:
            begin
                yw = {luma, 4'b0000};
                uw = {blue_diff, 4'b0000};
                vw = {red_diff, 4'b0000};
            end
            DEPTH_10:
            begin
                yw = {2'b00, luma, 2'b00};
                uw = {2'b00, blue_diff, 2'b00};
                vw = {2'b00, red_diff, 2'b00};
            end
            default:
            begin
                // 12-bit, and the unsupported code whose colours are dropped
                yw = {4'b0000, luma};
                uw = {4'b0000, blue_diff};
                vw = {4'b0000, red_diff};
            end
        endcase

        dy_next = $signed({2'b00, yw}) - Y_OFS;
        du_next = $signed({2'b00, uw}) - C_OFS;
        dv_next = $signed({2'b00, vw}) - C_OFS;

        // the q20 coefficients and the q4 samples give products in q24 code units
        py_next  = CH_W'(MUL_W'(dy_reg) * MUL_W'(C_YEXP));
        prv_next = CH_W'(MUL_W'(dv_reg) * MUL_W'(C_RV));
        pgu_next = CH_W'(MUL_W'(du_reg) * MUL_W'(C_GU));
        pgv_next = CH_W'(MUL_W'(dv_reg) * MUL_W'(C_GV));
        pbu_next = CH_W'(MUL_W'(du_reg) * MUL_W'(C_BU));

        r_next = py_reg + prv_reg;
        g_next = py_reg - pgu_reg - pgv_reg;
        b_next = py_reg + pbu_reg;
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        dy_reg  <= dy_next;
        du_reg  <= du_next;
        dv_reg  <= dv_next;
        py_reg  <= py_next;
        prv_reg <= prv_next;
        pgu_reg <= pgu_next;
        pgv_reg <= pgv_next;
        pbu_reg <= pbu_next;
        r_reg   <= r_next;
        g_reg   <= g_next;
        b_reg   <= b_next;
        ok_line_reg[0] <= s3_ok_reg;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            ok_line_reg[i] <= ok_line_reg[i-1];
        end
        s1_ok_reg <= (depth_mode_reg != DEPTH_BAD);
        s2_ok_reg <= s1_ok_reg;
        s3_ok_reg <= s2_ok_reg;
        // unsupported format gives zero colours
        red_reg   <= ok_line_reg[LANE_LAT-1] ? lane_r : '0;
        green_reg <= ok_line_reg[LANE_LAT-1] ? lane_g : '0;
        blue_reg  <= ok_line_reg[LANE_LAT-1] ? lane_b : '0;
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            valid_res_reg <= 1'b0;
            for (int i = 0; i < LANE_LAT; i++)
            begin
                valid_line_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg      <= accept;
            s2_valid_reg      <= s1_valid_reg;
            s3_valid_reg      <= s2_valid_reg;
            valid_line_reg[0] <= s3_valid_reg;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                valid_line_reg[i] <= valid_line_reg[i-1];
            end
            done_reg      <= valid_line_reg[LANE_LAT-1];
            valid_res_reg <= valid_line_reg[LANE_LAT-1] && ok_line_reg[LANE_LAT-1];
        end
    end

    // colour lanes
    ycl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r
    (
        .clk  (clk),
        .chan (r_reg),
        .lin  (lane_r)
    );

    ycl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g
    (
        .clk  (clk),
        .chan (g_reg),
        .lin  (lane_g)
    );

    ycl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b
    (
        .clk  (clk),
        .chan (b_reg),
        .lin  (lane_b)
    );

    assign done      = done_reg;
    assign valid_res = valid_res_reg;
    assign red_lin   = red_reg;
    assign green_lin = green_reg;
    assign blue_lin  = blue_reg;

`ifndef ASSERT_OFF
    // every transfer in is followed by its result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("result missing after input transfer");

    // no result without a transfer in at the matching cycle
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LAT))
        else $error("result without input transfer");

    // saturation keeps colours at or above the lower bound
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red_lin >= OUT_W'(OUT_MIN)) && (green_lin >= OUT_W'(OUT_MIN))
                 && (blue_lin >= OUT_W'(OUT_MIN)))
        else $error("colour below saturation floor");

    // unsupported format drops the colours
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (red_lin == '0) && (green_lin == '0) && (blue_lin == '0))
        else $error("non-zero colour on unsupported format");
`endif

endmodule

[verif/tb_ycbcr709_to_linear_rgb.sv]
// self-checking testbench for the bt.709 ycbcr to linear rgb converter
// drives pixel transfers and depth_mode writes, predicts each result in q24 integer maths
// depends on ycl_pkg and ycbcr709_to_linear_rgb
module tb_ycbcr709_to_linear_rgb;
    import ycl_pkg::*;

    // output fraction bits used for this build of the block
    localparam int FRAC        = 16;
    localparam int Q_INT       = 24;            // internal fraction bits of the predictor
    localparam int OUT_SHIFT   = Q_INT - FRAC;
    localparam int PIPE_LAT    = 15;            // transfer to result, matches PIPE_LAT in the block
    localparam int IDLE_PCT    = 29;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES      = 12;
    localparam int PHASE_LEN   = 120;
    localparam int CYCLE_LIMIT = 200000;

    // matrix and luma expansion, q20
    localparam longint K_YEXP = 1220945;
    localparam longint K_RV   = 1879782;
    localparam longint K_GU   = 223556;
    localparam longint K_GV   = 558786;
    localparam longint K_BU   = 2215012;
    // 1/255 and 1/4.5 in q32
    localparam longint K_INV255 = 16843009;
    localparam longint K_INV45  = 954437177;
    // knee of the linear segment and curve coefficients, q24
    localparam longint KNEE = 1358954;
    localparam longint CV_A = -696926;
    localparam longint CV_B = 3558112;
    localparam longint CV_C = 12187641;
    localparam longint CV_D = 1642171;
    localparam longint CV_E = 86151;
    // offsets and curve input cap, q24 code units
    localparam longint LUMA_OFS   = 64'sd16 <<< Q_INT;
    localparam longint CHROMA_OFS = 64'sd128 <<< Q_INT;
    localparam longint CURVE_CAP  = 64'sd8 <<< Q_INT;
    // saturation bounds of each colour
    localparam longint OUT_LO = -131072;
    localparam longint OUT_HI = 524287;

    typedef struct {
        logic [SMP_W-1:0] luma;
        logic [SMP_W-1:0] cb;
        logic [SMP_W-1:0] cr;
    } pixel_t;

    typedef struct {
        logic signed [OUT_W-1:0] red;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] blue;
        logic                    valid;
    } rgb_lin_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [SMP_W-1:0]        luma = '0;
    logic [SMP_W-1:0]        blue_diff = '0;
    logic [SMP_W-1:0]        red_diff = '0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_wdata = DEPTH_8;
    logic                    done;
    logic signed [OUT_W-1:0] red_lin;
    logic signed [OUT_W-1:0] green_lin;
    logic signed [OUT_W-1:0] blue_lin;
    logic                    valid_res;

    // pixels waiting for the driver, and predicted results in transfer order
    pixel_t      pixels_to_send[$];
    rgb_lin_t    rgb_pending[$];
    depth_mode_t depth_now = DEPTH_8;   // predictor's copy of the mode register
    int          pixels_queued = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          cycle_cnt = 0;
    logic        pix_taken = 1'b0;      // start was accepted at the last rising edge
    logic        steady = 1'b0;         // no idle cycles on the sending side

    ycbcr709_to_linear_rgb #(
        .FRAC_BITS (FRAC)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .luma      (luma),
        .blue_diff (blue_diff),
        .red_diff  (red_diff),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .red_lin   (red_lin),
        .green_lin (green_lin),
        .blue_lin  (blue_lin),
        .valid_res (valid_res)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // round half up on a right shift, floor semantics for negative values
    function automatic longint round_shr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // code units (q24) to linear light (q24): linear segment below the knee, quartic above
    function automatic longint light_from_code(longint c);
        longint x;
        longint acc;
        x = round_shr(c * K_INV255, 32);
        if (x < KNEE)
            return round_shr(x * K_INV45, 32);
        if (x > CURVE_CAP)
            x = CURVE_CAP;
        acc = CV_A;
        acc = round_shr(acc * x, Q_INT) + CV_B;
        acc = round_shr(acc * x, Q_INT) + CV_C;
        acc = round_shr(acc * x, Q_INT) + CV_D;
        acc = round_shr(acc * x, Q_INT) + CV_E;
        return acc;
    endfunction

    // q24 to output fraction bits, saturated
    function automatic logic signed [OUT_W-1:0] to_output(longint v);
        longint o;
        o = round_shr(v, OUT_SHIFT);
        if (o < OUT_LO)
            o = OUT_LO;
        if (o > OUT_HI)
            o = OUT_HI;
        return o[OUT_W-1:0];
    endfunction

    function automatic rgb_lin_t predict_linear_rgb(pixel_t p, depth_mode_t m);
        rgb_lin_t res;
        int       sh;
        longint   ys;
        longint   us;
        longint   vs;
        longint   y;
        longint   cb;
        longint   cr;
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
        res.valid = 1'b0;
        // unsupported format: zero colours, valid low
        if (m == DEPTH_BAD)
            return res;
        // scale to 8-bit code values; samples above the depth are used as they are
        sh = Q_INT - 2 * int'(m);
        ys = longint'({52'd0, p.luma});
        us = longint'({52'd0, p.cb});
        vs = longint'({52'd0, p.cr});
        ys = ys <<< sh;
        us = us <<< sh;
        vs = vs <<< sh;
        y  = round_shr((ys - LUMA_OFS) * K_YEXP, 20);
        cb = us - CHROMA_OFS;
        cr = vs - CHROMA_OFS;
        res.red   = to_output(light_from_code(y + round_shr(cr * K_RV, 20)));
        res.green = to_output(light_from_code(y - round_shr(cb * K_GU, 20)
                                                - round_shr(cr * K_GV, 20)));
        res.blue  = to_output(light_from_code(y + round_shr(cb * K_BU, 20)));
        res.valid = 1'b1;
        return res;
    endfunction

    // ---------------------------------------------------------------- driver

    // inputs change on the falling edge; a held transfer keeps start high without a gap
    always @(negedge clk)
    begin : pixel_driver
        pixel_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || pix_taken)
        begin
            if (pixels_to_send.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = pixels_to_send.pop_front();
                luma      <= nxt.luma;
                blue_diff <= nxt.cb;
                red_diff  <= nxt.cr;
                start     <= 1'b1;
            end
            else
            begin
                // idle cycle: fields carry noise that the block must ignore
                luma      <= SMP_W'($urandom_range(0, 4095));
                blue_diff <= SMP_W'($urandom_range(0, 4095));
                red_diff  <= SMP_W'($urandom_range(0, 4095));
                start     <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // results are checked before the new transfer is predicted, so a result and a
    // transfer on the same edge never pair up
    always @(posedge clk)
    begin : result_monitor
        rgb_lin_t want;
        pixel_t   p;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (rgb_pending.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result with nothing outstanding: r=%0d g=%0d b=%0d v=%0b",
                                 red_lin, green_lin, blue_lin, valid_res);
                end
                else
                begin
                    want = rgb_pending.pop_front();
                    if (red_lin !== want.red || green_lin !== want.green ||
                        blue_lin !== want.blue || valid_res !== want.valid)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("mismatch: expected r=%0d g=%0d b=%0d v=%0b",
                                     want.red, want.green, want.blue, want.valid);
                            $display("          got      r=%0d g=%0d b=%0d v=%0b",
                                     red_lin, green_lin, blue_lin, valid_res);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                p.luma = luma;
                p.cb   = blue_diff;
                p.cr   = red_diff;
                rgb_pending.push_back(predict_linear_rgb(p, depth_now));
            end
        end
        pix_taken <= start && !busy;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[ycbcr709_to_linear_rgb] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_pixel(int y, int u, int v);
        pixel_t p;
        p.luma = y[SMP_W-1:0];
        p.cb   = u[SMP_W-1:0];
        p.cr   = v[SMP_W-1:0];
        pixels_to_send.push_back(p);
        pixels_queued++;
    endtask

    // every queued pixel has been transferred and its result has come back
    task automatic wait_drained();
        while (results_seen < pixels_queued)
            @(negedge clk);
    endtask

    // mode register write, only while nothing is in flight
    task automatic set_depth(depth_mode_t m);
        @(negedge clk);
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        depth_now = m;
    endtask

    // code value in [lo, hi] at the given scale, with random sub-code bits
    function automatic int code_sample(int lo, int hi, int scale);
        return $urandom_range(lo, hi) * scale + $urandom_range(0, scale - 1);
    endfunction

    task automatic queue_random(depth_mode_t m);
        int scale;
        int pick;
        int y;
        int u;
        int v;
        scale = (m == DEPTH_BAD) ? 1 : (1 << (2 * int'(m)));
        pick  = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // nominal video range
            y = code_sample(16, 235, scale);
            u = code_sample(16, 240, scale);
            v = code_sample(16, 240, scale);
        end
        else if (pick < 70)
        begin
            // dark greys around the knee of the transfer curve
            y = code_sample(28, 40, scale);
            u = code_sample(124, 132, scale);
            v = code_sample(124, 132, scale);
        end
        else if (pick < 80)
        begin
            // corners of the sample space
            y = $urandom_range(0, 1) * 4095;
            u = $urandom_range(0, 1) * 4095;
            v = $urandom_range(0, 1) * 4095;
        end
        else
        begin
            y = $urandom_range(0, 4095);
            u = $urandom_range(0, 4095);
            v = $urandom_range(0, 4095);
        end
        queue_pixel(y, u, v);
    endtask

    initial
    begin : stimulus
        depth_mode_t m;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // 8-bit: black, white, extremes, the knee, curve clamp and saturation
        set_depth(DEPTH_8);
        queue_pixel(0, 0, 0);
        queue_pixel(4095, 4095, 4095);
        queue_pixel(16, 128, 128);
        queue_pixel(235, 128, 128);
        queue_pixel(33, 128, 128);
        queue_pixel(34, 128, 128);
        queue_pixel(4095, 128, 128);      // huge curve input, clamped
        queue_pixel(235, 240, 240);
        queue_pixel(16, 16, 16);
        queue_pixel(0, 4095, 4095);       // green far below zero
        queue_pixel(235, 16, 240);
        queue_pixel(2730, 1365, 2730);
        queue_pixel(1365, 2730, 1365);

        // deepest setting, including samples above nominal range
        wait_drained();
        set_depth(DEPTH_12);
        queue_pixel(0, 0, 0);
        queue_pixel(4095, 4095, 4095);
        queue_pixel(3760, 2048, 2048);
        queue_pixel(256, 2048, 2048);

        wait_drained();
        set_depth(DEPTH_10);
        queue_pixel(940, 512, 512);
        queue_pixel(64, 960, 64);

        // unsupported format gives valid low and zero colours
        wait_drained();
        set_depth(DEPTH_BAD);
        queue_pixel(4095, 0, 4095);
        queue_pixel(1365, 2730, 1365);

        // random phases, one mode each; one phase runs with no idle cycles
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: m = DEPTH_10;
                1: m = DEPTH_8;
                2: m = DEPTH_12;
                3: m = DEPTH_BAD;
                default: m = ($urandom_range(0, 9) == 0) ? DEPTH_BAD
                                                          : depth_mode_t'($urandom_range(0, 2));
            endcase
            set_depth(m);
            steady = (ph == 5);
            repeat (PHASE_LEN) queue_random(m);
        end

        wait_drained();
        repeat (2 * PIPE_LAT) @(negedge clk);
        if (errors == 0 && rgb_pending.size() == 0)
            $display("[ycbcr709_to_linear_rgb] OK");
        else
            $display("[ycbcr709_to_linear_rgb] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/ycl_pkg.sv
rtl/ycl_lane.sv
rtl/ycbcr709_to_linear_rgb.sv
verif/tb_ycbcr709_to_linear_rgb.sv
